FILE: design/ttwd_pkg.sv
// Package for the trellis tile weight decoder.
// Holds tile sizes, opcodes, register indexes, bank mask table, hash constants,
// the structs passed between modules and the segment mask function. No dependencies.
package ttwd_pkg;

  localparam int CODES_PER_TILE    = 128;
  localparam int MAX_PAYLOAD_WORDS = 64;

  localparam int CODE_W = $clog2(CODES_PER_TILE);
  localparam int PW_AW  = $clog2(MAX_PAYLOAD_WORDS);
  localparam int PROD_W = CODE_W + 3;
  localparam int WIDX_W = 8;

  typedef enum logic [1:0] {
    OP_LEVEL   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_BANK    = 2'd2,
    OP_DECODE  = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_TBITS = 2'd0;
  localparam logic [1:0] CFG_FMT   = 2'd1;
  localparam logic [1:0] CFG_ALT   = 2'd2;

  localparam logic [1:0] FMT_ONE      = 2'd0;
  localparam logic [1:0] FMT_FOUR     = 2'd1;
  localparam logic [1:0] FMT_EIGHT    = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  localparam logic [4:0] E_MIN      = 5'd2;
  localparam logic [4:0] E_MAX      = 5'd16;
  localparam logic [4:0] E_MASK_MAX = 5'd7;
  localparam logic [5:0] WIN_BITS   = 6'd16;

  localparam logic [15:0] HASH_MUL = 16'd40503;
  localparam logic [15:0] HASH_ADD = 16'd17011;

  localparam logic [15:0] BANK_MASKS [6][4] = '{
    '{16'h0000, 16'hA5A5, 16'h5A5A, 16'h3C3C},
    '{16'h0000, 16'hA5A5, 16'h9696, 16'h6969},
    '{16'h0000, 16'h5A5A, 16'h3C3C, 16'hC3C3},
    '{16'h0000, 16'h9696, 16'h3C3C, 16'hC3C3},
    '{16'h0000, 16'h6969, 16'h5A5A, 16'h3C3C},
    '{16'h0000, 16'hC3C3, 16'h9696, 16'h5A5A}
  };

  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] step;
    logic [4:0]        e;
  } gather_req_t;

  typedef struct packed {
    logic             en;
    logic [PW_AW-1:0] addr;
    logic [31:0]      data;
  } pay_wr_t;

  typedef struct packed {
    logic        start;
    logic [15:0] window;
    logic [15:0] mask;
  } lk_req_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [15:0] data;
  } lvl_wr_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] first;
    logic [15:0] second;
  } lk_res_t;

  // Bank mask of the segment that holds the given step. The segment index is
  // found by comparing step*segments against multiples of the tile length.
  function automatic logic [15:0] seg_mask(
    input logic [CODE_W-1:0] step,
    input logic [4:0]        e,
    input logic [1:0]        fmt,
    input logic [1:0]        alt,
    input logic [7:0]        bank
  );
    logic [1:0]        f;
    logic [3:0]        nseg;
    logic [PROD_W-1:0] prod;
    logic [2:0]        seg;
    logic [1:0]        sel;
    logic [1:0]        col;
    logic [15:0]       res;
    f = (fmt == FMT_RESERVED) ? FMT_ONE : fmt;
    if (f == FMT_EIGHT) begin
      nseg = 4'd8;
      prod = {step, 3'b000};
    end else if (f == FMT_FOUR) begin
      nseg = 4'd4;
      prod = {1'b0, step, 2'b00};
    end else begin
      nseg = 4'd1;
      prod = {3'b000, step};
    end
    seg = 3'd0;
    for (int g = 1; g < 8; g++) begin
      if (g < int'(nseg) && prod >= PROD_W'(g * CODES_PER_TILE)) seg = seg + 3'd1;
    end
    if (f == FMT_EIGHT) begin
      sel = {1'b0, bank[seg]};
      col = alt;
    end else begin
      sel = 2'(bank >> {seg[1:0], 1'b0});
      col = sel;
    end
    if (sel == 2'd0 || e < E_MIN || e > E_MASK_MAX) res = 16'h0000;
    else res = BANK_MASKS[3'(e - E_MIN)][col];
    return res;
  endfunction

endpackage

FILE: design/ttwd_if.sv
// Stream interfaces for the trellis tile weight decoder: the item channel and
// the result channel, each with valid, ready and payload. No dependencies.
interface ttwd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  item_index;
  logic [31:0] item_data;

  modport source (output valid, output opcode, output item_index, output item_data,
                  input ready);
  modport sink   (input valid, input opcode, input item_index, input item_data,
                  output ready);
endinterface

interface ttwd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight_first;
  logic [15:0] weight_second;

  modport source (output valid, output weight_first, output weight_second, input ready);
  modport sink   (input valid, input weight_first, input weight_second, output ready);
endinterface

FILE: design/ttwd_field_shift.sv
// Shared shift unit of the gather sequencer: extracts one bit-plane field from
// a payload word and places it in the 16-bit window. Depends on ttwd_pkg.
module ttwd_field_shift
  import ttwd_pkg::*;
(
  input  logic [31:0] word,
  input  logic [4:0]  shift,
  input  logic [2:0]  lw,
  input  logic [4:0]  pos,
  input  logic        zero,
  output logic [15:0] contrib
);

  logic [31:0] shifted;
  logic [4:0]  w;
  logic [16:0] mask17;
  logic [15:0] field;
  logic [31:0] placed;

  always_comb begin
    shifted = word >> shift;
    w       = 5'd1 << lw;
    mask17  = (17'd1 << w) - 17'd1;
    field   = shifted[15:0] & mask17[15:0];
    placed  = {16'h0000, field} << pos;
    contrib = zero ? 16'h0000 : placed[15:0];
  end

endmodule

FILE: design/ttwd_gather.sv
// Gather sequencer: holds the planar payload memory and walks the codes and
// bit planes of the window, one payload read per cycle. Depends on ttwd_pkg
// and ttwd_field_shift.
module ttwd_gather
  import ttwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  gather_req_t req,
  input  pay_wr_t     wr,
  output logic        done,
  output logic [15:0] window
);

  typedef enum logic [3:0] {
    G_IDLE  = 4'b0001,
    G_RUN   = 4'b0010,
    G_DRAIN = 4'b0100,
    G_FIN   = 4'b1000
  } gstate_t;

  gstate_t state;

  logic [31:0] pay_mem [MAX_PAYLOAD_WORDS];
  logic [31:0] rd_word;

  logic [CODE_W-1:0] c;
  logic [4:0]        rem;
  logic [4:0]        o;
  logic [4:0]        cb;
  logic [4:0]        e_reg;
  logic [15:0]       win;

  logic        pend_valid;
  logic [4:0]  pend_kw;
  logic [2:0]  pend_lw;
  logic [4:0]  pend_pos;
  logic        pend_zero;

  logic [2:0]        lw;
  logic [4:0]        w;
  logic [4:0]        jj;
  logic [2:0]        pwsh;
  logic [4:0]        pw;
  logic [4:0]        k;
  logic [4:0]        kw;
  logic [WIDX_W-1:0] block;
  logic [WIDX_W-1:0] base;
  logic [WIDX_W-1:0] widx;
  logic              in_range;
  logic [PW_AW-1:0]  rd_addr;
  logic [4:0]        pos;
  logic [4:0]        rem_left;
  logic [5:0]        cb_sum;
  logic [CODE_W-1:0] c_prev;
  logic [15:0]       contrib;

  // Plane width is the largest power of two not above the bits still to fetch.
  always_comb begin
    if (rem[4])      lw = 3'd4;
    else if (rem[3]) lw = 3'd3;
    else if (rem[2]) lw = 3'd2;
    else if (rem[1]) lw = 3'd1;
    else             lw = 3'd0;
    w        = 5'd1 << lw;
    jj       = c[4:0];
    pwsh     = 3'd5 - lw;
    pw       = jj >> pwsh;
    k        = jj & ~(5'h1F << pwsh);
    kw       = k << lw;
    block    = WIDX_W'(c >> 5);
    base     = WIDX_W'(block * e_reg);
    widx     = base + WIDX_W'(o) + WIDX_W'(pw);
    in_range = widx < WIDX_W'(MAX_PAYLOAD_WORDS);
    rd_addr  = widx[PW_AW-1:0];
    pos      = cb + o;
    rem_left = rem - w;
    cb_sum   = {1'b0, cb} + {1'b0, e_reg};
    c_prev   = (c == '0) ? CODE_W'(CODES_PER_TILE - 1) : c - CODE_W'(1);
  end

  ttwd_field_shift u_shift (
    .word    (rd_word),
    .shift   (pend_kw),
    .lw      (pend_lw),
    .pos     (pend_pos),
    .zero    (pend_zero),
    .contrib (contrib)
  );

  always_ff @(posedge clk) begin
    if (wr.en) pay_mem[wr.addr] <= wr.data;
    rd_word <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_IDLE;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == G_RUN);
      pend_kw    <= kw;
      pend_lw    <= lw;
      pend_pos   <= pos;
      pend_zero  <= !in_range;
      if (pend_valid) win <= win | contrib;
      unique case (state)
        G_IDLE: begin
          if (req.start) begin
            c     <= req.step;
            rem   <= req.e;
            o     <= 5'd0;
            cb    <= 5'd0;
            e_reg <= req.e;
            win   <= 16'h0000;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (rem_left == 5'd0) begin
            if (cb_sum >= WIN_BITS) begin
              state <= G_DRAIN;
            end else begin
              c   <= c_prev;
              rem <= e_reg;
              o   <= 5'd0;
              cb  <= cb_sum[4:0];
            end
          end else begin
            rem <= rem_left;
            o   <= o + w;
          end
        end
        G_DRAIN: state <= G_FIN;
        G_FIN:   state <= G_IDLE;
        default: state <= G_IDLE;
      endcase
    end
  end

  assign done   = (state == G_FIN);
  assign window = win;

endmodule

FILE: design/ttwd_lookup.sv
// Hash and codebook stage: folds and hashes the masked window, then reads the
// two half-float levels from the level codebook memory. Depends on ttwd_pkg.
module ttwd_lookup
  import ttwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  lk_req_t req,
  input  lvl_wr_t wr,
  input  logic    take,
  output lk_res_t res
);

  typedef enum logic [4:0] {
    L_IDLE  = 5'b00001,
    L_MUL   = 5'b00010,
    L_ADDR1 = 5'b00100,
    L_ADDR2 = 5'b01000,
    L_HOLD  = 5'b10000
  } lstate_t;

  lstate_t state;

  logic [15:0] cb_mem [256];
  logic [15:0] rd_data;
  logic [7:0]  rd_addr;
  logic        rd_en;

  logic [15:0] st;
  logic [15:0] fold;
  logic [15:0] m2;
  logic [15:0] h;
  logic [7:0]  h_lo;
  logic [15:0] first_reg;

  always_comb begin
    fold    = st ^ (st >> 8);
    h       = m2 ^ (m2 >> 7);
    rd_en   = (state == L_ADDR1) || (state == L_ADDR2);
    rd_addr = (state == L_ADDR1) ? h[15:8] : h_lo;
  end

  always_ff @(posedge clk) begin
    if (wr.en) cb_mem[wr.addr] <= wr.data;
    if (rd_en) rd_data <= cb_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            st    <= req.window ^ req.mask;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          m2    <= 16'(fold * HASH_MUL + HASH_ADD);
          state <= L_ADDR1;
        end
        L_ADDR1: begin
          h_lo  <= h[7:0];
          state <= L_ADDR2;
        end
        L_ADDR2: begin
          first_reg <= rd_data;
          state     <= L_HOLD;
        end
        L_HOLD: begin
          if (take) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign res.valid  = (state == L_HOLD);
  assign res.first  = first_reg;
  assign res.second = rd_data;

endmodule

FILE: design/trellis_tile_weight_decoder_core.sv
// Top level of the trellis tile weight decoder: item handshake, configuration
// registers, bank byte and result register. Depends on ttwd_pkg, ttwd_if,
// ttwd_gather and ttwd_lookup.
//
//   channel  | dir | fields                               | handshake
//   in_ch    | in  | opcode, item_index, item_data        | valid/ready
//   out_ch   | out | weight_first, weight_second          | valid/ready
//   cfg      | in  | cfg_index, cfg_data                  | cfg_we, no wait
//
// Load items are written as they are accepted. For a decode, the gather issues
// R = ceil(16/E) * popcount(E) payload reads (1 to 12), one per cycle through the
// single read port of the payload memory; the lookup then loads the result register,
// and the input is taken up again only after the result has moved there.
// Reset is synchronous; it clears control state and the bank byte and sets
// the code width to 2. Stores stay undefined until written.
// in_ch.ready is low while a decode is in flight; a result waits in the
// lookup stage while out_ch stalls with a result already held.
module trellis_tile_weight_decoder_core
  import ttwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ttwd_in_if.sink          in_ch,
  ttwd_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [4:0]       cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_GATHER = 3'b010,
    T_LOOKUP = 3'b100
  } tstate_t;

  tstate_t state;

  logic [4:0]  code_bits;
  logic [1:0]  bank_format;
  logic [1:0]  alt_column;
  logic [7:0]  tile_bank;
  logic [15:0] mask_reg;

  logic        out_valid;
  logic [15:0] out_first;
  logic [15:0] out_second;

  logic        accept;
  logic        dec_start;
  logic [4:0]  e_eff;
  logic        take;

  gather_req_t g_req;
  pay_wr_t     p_wr;
  lk_req_t     l_req;
  lvl_wr_t     v_wr;
  lk_res_t     res;
  logic        g_done;
  logic [15:0] g_window;

  always_comb begin
    accept    = in_ch.valid && in_ch.ready;
    dec_start = accept && (in_ch.opcode == OP_DECODE) &&
                (in_ch.item_index < 8'(CODES_PER_TILE));
    if (code_bits < E_MIN)      e_eff = E_MIN;
    else if (code_bits > E_MAX) e_eff = E_MAX;
    else                        e_eff = code_bits;
    take = !out_valid || out_ch.ready;

    g_req.start = dec_start;
    g_req.step  = in_ch.item_index[CODE_W-1:0];
    g_req.e     = e_eff;

    p_wr.en   = accept && (in_ch.opcode == OP_PAYLOAD) &&
                (in_ch.item_index < 8'(MAX_PAYLOAD_WORDS));
    p_wr.addr = in_ch.item_index[PW_AW-1:0];
    p_wr.data = in_ch.item_data;

    v_wr.en   = accept && (in_ch.opcode == OP_LEVEL);
    v_wr.addr = in_ch.item_index;
    v_wr.data = in_ch.item_data[15:0];

    l_req.start  = g_done;
    l_req.window = g_window;
    l_req.mask   = mask_reg;
  end

  assign in_ch.ready = (state == T_IDLE);

  ttwd_gather u_gather (
    .clk    (clk),
    .rst    (rst),
    .req    (g_req),
    .wr     (p_wr),
    .done   (g_done),
    .window (g_window)
  );

  ttwd_lookup u_lookup (
    .clk  (clk),
    .rst  (rst),
    .req  (l_req),
    .wr   (v_wr),
    .take (take),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits   <= E_MIN;
      bank_format <= FMT_ONE;
      alt_column  <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TBITS: code_bits   <= cfg_data;
        CFG_FMT:   bank_format <= cfg_data[1:0];
        CFG_ALT:   alt_column  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_bank <= 8'h00;
    end else if (accept && in_ch.opcode == OP_BANK) begin
      tile_bank <= in_ch.item_data[7:0];
    end
  end

  // The user keeps the mask inputs static in a decode; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (dec_start) begin
      mask_reg <= seg_mask(in_ch.item_index[CODE_W-1:0], e_eff, bank_format,
                           alt_column, tile_bank);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE:   if (dec_start) state <= T_GATHER;
        T_GATHER: if (g_done) state <= T_LOOKUP;
        T_LOOKUP: if (res.valid && take) state <= T_IDLE;
        default:  state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && take) begin
      out_first  <= res.first;
      out_second <= res.second;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.weight_first  = out_first;
  assign out_ch.weight_second = out_second;

  a_done_in_gather: assert property (@(posedge clk) disable iff (rst)
    g_done |-> state == T_GATHER)
    else $error("gather finished outside the gather phase");

  a_res_in_lookup: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> state == T_LOOKUP)
    else $error("lookup result outside the lookup phase");

  a_decode_starts: assert property (@(posedge clk) disable iff (rst)
    dec_start |=> state == T_GATHER && !in_ch.ready)
    else $error("decode transaction did not start the gather");

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    res.valid && take |=> out_valid && state == T_IDLE)
    else $error("result not moved to the output register");

endmodule
